// ----- rtl/core/ffa_pkg.sv -----
// Package for the first-fit slot bitmap allocator: sizes, the sequencer state type,
// the memory request struct and the per-word slot mask function.
// No dependencies; every other file in rtl/core imports it.
package ffa_pkg;

	localparam int SLOTS          = 1024;
	localparam int ROOMS          = 8;
	localparam int WORD_BITS      = 64;
	localparam int WORD_SHIFT     = 6;
	localparam int WORDS_PER_ROOM = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int MEM_DEPTH      = ROOMS * WORDS_PER_ROOM;
	localparam int ADDR_W         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int WORD_AW        = (WORDS_PER_ROOM > 1) ? $clog2(WORDS_PER_ROOM) : 1;
	localparam int ROOM_CNT_W     = $clog2(ROOMS + 1);

	// Widths of the interface fields.
	localparam int SLOT_W   = 11;
	localparam int SWORD_W  = SLOT_W - WORD_SHIFT;
	localparam int ROOMIX_W = 3;
	localparam int CFG_W    = 4;

	localparam logic [CFG_W-1:0] ROOMS_RESET = CFG_W'(8);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FINISH
	} ffa_state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		word_t             wr_data;
	} mem_req_t;

	// Bits of bitmap word w that lie inside the half-open slot range [lo, hi).
	function automatic word_t word_mask(input logic [WORD_AW-1:0] w,
		input logic [SLOT_W-1:0] lo, input logic [SLOT_W-1:0] hi);
		logic [SWORD_W-1:0] wd;
		logic [SWORD_W-1:0] lw;
		logic [SWORD_W-1:0] hw;
		word_t              lo_m;
		word_t              hi_m;
		wd = SWORD_W'(w);
		lw = lo[SLOT_W-1:WORD_SHIFT];
		hw = hi[SLOT_W-1:WORD_SHIFT];
		if (wd > lw) begin
			lo_m = '1;
		end else if (wd == lw) begin
			lo_m = '1 << lo[WORD_SHIFT-1:0];
		end else begin
			lo_m = '0;
		end
		if (wd < hw) begin
			hi_m = '1;
		end else if (wd == hw) begin
			hi_m = ~('1 << hi[WORD_SHIFT-1:0]);
		end else begin
			hi_m = '0;
		end
		return lo_m & hi_m;
	endfunction

endpackage

// ----- rtl/core/ffa_ifs.sv -----
// Handshake channel interfaces of the allocator: request, response and configuration.
// Depends on ffa_pkg for the field widths.
interface ffa_req_if import ffa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SLOT_W-1:0] start_slot;
	logic [SLOT_W-1:0] end_slot;

	modport source (output valid, req_type, start_slot, end_slot, input ready);
	modport sink (input valid, req_type, start_slot, end_slot, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                granted;
	logic [ROOMIX_W-1:0] room_index;

	modport source (output valid, granted, room_index, input ready);
	modport sink (input valid, granted, room_index, output ready);
endinterface

interface ffa_cfg_if import ffa_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/core/first_fit_slot_bitmap_allocator_core.sv -----
// Top level of the first-fit slot bitmap allocator: configuration register and the
// sequencer and bitmap memory instances. Depends on ffa_pkg, ffa_ifs, ffa_scan_ctrl, ffa_bitmap_ram.
//
// Each request beat names a half-open slot range [start_slot, end_slot) and either books
// it in the first active room whose bitmap has the whole range free, or only asks whether
// such a room exists. One response beat follows each request. The bitmaps live in one
// 64-bit wide synchronous memory, read one word per cycle. A request scans the active rooms in
// order, reading the words that the range spans in each and moving on at the first taken
// slot; a booking then reads, sets and writes back those words in the chosen room.
// Empty ranges and a zero room count skip the scan.
// A new request is taken while the previous response
// still waits in the output register. rooms_in_use may only be written while idle.
module first_fit_slot_bitmap_allocator_core import ffa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ffa_cfg_if.sink   cfg,
	ffa_req_if.sink   req,
	ffa_rsp_if.source rsp
);

	logic [CFG_W-1:0]      rooms_in_use_q;
	logic [ROOM_CNT_W-1:0] active;
	mem_req_t              mem_req;
	word_t                 rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rooms_in_use_q <= ROOMS_RESET;
		end else if (cfg.valid) begin
			rooms_in_use_q <= cfg.data;
		end
	end

	// A room count beyond the rooms that exist is clamped.
	assign active = (int'(rooms_in_use_q) > ROOMS) ? ROOM_CNT_W'(ROOMS)
		: ROOM_CNT_W'(rooms_in_use_q);

	ffa_scan_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.active  (active),
		.req     (req),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	ffa_bitmap_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

endmodule

// ----- rtl/core/ffa_bitmap_ram.sv -----
// Occupancy bitmap memory: one write and one read port, registered read data.
// Depends on ffa_pkg. Per-entry valid bits make unwritten words read as all free.
module ffa_bitmap_ram import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output word_t    rdata
);

	word_t                mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	word_t                rdata_q;
	logic                 rvld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// ----- rtl/core/ffa_scan_ctrl.sv -----
// Scan and mark sequencer: reads bitmap words room by room, checks them against the
// range mask, writes a booking back, and holds the response register. Depends on ffa_pkg.
module ffa_scan_ctrl import ffa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ROOM_CNT_W-1:0] active,
	ffa_req_if.sink               req,
	ffa_rsp_if.source             rsp,
	output mem_req_t              mem_req,
	input  word_t                 rdata
);

	ffa_state_t            state_q, state_d;
	logic                  is_ask_q, is_ask_d;
	logic [SLOT_W-1:0]     lo_q, lo_d, hi_q, hi_d;
	logic [WORD_AW-1:0]    first_w_q, first_w_d, last_w_q, last_w_d;
	logic [ROOM_CNT_W-1:0] room_q, room_d;
	logic [WORD_AW-1:0]    word_q, word_d;
	logic                  iss_done_q, iss_done_d;
	logic                  grant_q, grant_d;
	logic                  v_s1, v_s1_d;
	logic [WORD_AW-1:0]    word_s1, word_s1_d;
	logic                  last_s1, last_s1_d;
	logic                  out_valid_q, out_valid_d;
	logic                  out_granted_q, out_granted_d;
	logic [ROOMIX_W-1:0]   out_room_q, out_room_d;

	logic [SLOT_W-1:0]     lo_in, hi_in, hi_m1;
	word_t                 mask_s1;
	logic                  hit;

	function automatic logic [ADDR_W-1:0] word_addr(input logic [ROOM_CNT_W-1:0] r,
		input logic [WORD_AW-1:0] w);
		return ADDR_W'(int'(r) * WORDS_PER_ROOM + int'(w));
	endfunction

	// Saturate the incoming range to the slot space; a reversed range becomes empty.
	always_comb begin
		lo_in = (int'(req.start_slot) > SLOTS) ? SLOT_W'(SLOTS) : req.start_slot;
		hi_in = (int'(req.end_slot) > SLOTS) ? SLOT_W'(SLOTS) : req.end_slot;
		if (hi_in < lo_in) begin
			hi_in = lo_in;
		end
		hi_m1 = hi_in - SLOT_W'(1);
	end

	assign mask_s1 = word_mask(word_s1, lo_q, hi_q);
	assign hit     = v_s1 && ((rdata & mask_s1) != '0);

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.granted    = out_granted_q;
	assign rsp.room_index = out_room_q;

	always_comb begin
		state_d       = state_q;
		is_ask_d      = is_ask_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		first_w_d     = first_w_q;
		last_w_d      = last_w_q;
		room_d        = room_q;
		word_d        = word_q;
		iss_done_d    = iss_done_q;
		grant_d       = grant_q;
		v_s1_d        = 1'b0;
		word_s1_d     = word_s1;
		last_s1_d     = last_s1;
		out_valid_d   = out_valid_q && !rsp.ready;
		out_granted_d = out_granted_q;
		out_room_d    = out_room_q;
		mem_req       = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					is_ask_d   = req.req_type;
					lo_d       = lo_in;
					hi_d       = hi_in;
					first_w_d  = WORD_AW'(lo_in >> WORD_SHIFT);
					last_w_d   = WORD_AW'(hi_m1 >> WORD_SHIFT);
					word_d     = WORD_AW'(lo_in >> WORD_SHIFT);
					room_d     = '0;
					iss_done_d = 1'b0;
					if (active == '0) begin
						grant_d = 1'b0;
						state_d = ST_FINISH;
					end else if (hi_in == lo_in) begin
						grant_d = 1'b1;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					// This room is taken somewhere in the range; drop the beat in flight.
					if (room_q + ROOM_CNT_W'(1) == active) begin
						grant_d = 1'b0;
						room_d  = '0;
						state_d = ST_FINISH;
					end else begin
						room_d     = room_q + ROOM_CNT_W'(1);
						word_d     = first_w_q;
						iss_done_d = 1'b0;
					end
				end else if (v_s1 && last_s1) begin
					grant_d = 1'b1;
					if (is_ask_q) begin
						state_d = ST_FINISH;
					end else begin
						word_d     = first_w_q;
						iss_done_d = 1'b0;
						state_d    = ST_MARK;
					end
				end else if (!iss_done_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = word_addr(room_q, word_q);
					v_s1_d          = 1'b1;
					word_s1_d       = word_q;
					last_s1_d       = (word_q == last_w_q);
					iss_done_d      = (word_q == last_w_q);
					word_d          = word_q + WORD_AW'(1);
				end
			end
			ST_MARK: begin
				// Read of word w+1 overlaps the write of word w; they never share an entry.
				if (v_s1) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = word_addr(room_q, word_s1);
					mem_req.wr_data = rdata | mask_s1;
				end
				if (v_s1 && last_s1) begin
					state_d = ST_FINISH;
				end else if (!iss_done_q) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = word_addr(room_q, word_q);
					v_s1_d          = 1'b1;
					word_s1_d       = word_q;
					last_s1_d       = (word_q == last_w_q);
					iss_done_d      = (word_q == last_w_q);
					word_d          = word_q + WORD_AW'(1);
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_valid_d   = 1'b1;
					out_granted_d = grant_q;
					out_room_d    = grant_q ? ROOMIX_W'(room_q) : '0;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			iss_done_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			v_s1        <= v_s1_d;
			out_valid_q <= out_valid_d;
			iss_done_q  <= iss_done_d;
		end
	end

	always_ff @(posedge clk) begin
		is_ask_q      <= is_ask_d;
		lo_q          <= lo_d;
		hi_q          <= hi_d;
		first_w_q     <= first_w_d;
		last_w_q      <= last_w_d;
		room_q        <= room_d;
		word_q        <= word_d;
		grant_q       <= grant_d;
		word_s1       <= word_s1_d;
		last_s1       <= last_s1_d;
		out_granted_q <= out_granted_d;
		out_room_q    <= out_room_d;
	end

endmodule
